[hdl/cec_pkg.sv]
package cec_pkg;

   localparam int POS_WIDTH = 33;
   localparam logic [POS_WIDTH-1:0] POS_SAT = 33'h1_0000_0000;
   localparam logic [POS_WIDTH-1:0] ENV_BYTES = 33'd24;
   localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTOCOL_VERSION = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ENCODED_BYTES = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LIMIT    = 3'd1,
      ST_TRUNC    = 3'd2,
      ST_MAGIC    = 3'd3,
      ST_VERSION  = 3'd4,
      ST_INVALID  = 3'd5,
      ST_TRAILING = 3'd6,
      ST_CHECKSUM = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_out;
      logic       frame_done;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  magic_bad;
      logic [15:0] version;
      logic [15:0] reserved;
      logic [63:0] length;
      logic [63:0] sum;
   } hdr_type;

   // Expected envelope magic, "SWRW".
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0: val = 8'h53;
         2'd1: val = 8'h57;
         2'd2: val = 8'h52;
         2'd3: val = 8'h57;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // The FNV-1a 64 prime is 2^40 + 2^8 + 0xB3, so the product is a sum of shifts.
   function automatic logic [63:0] fnv_mul(input logic [63:0] acc);
      return (acc << 40) + (acc << 8) + (acc << 7) + (acc << 5) + (acc << 4)
             + (acc << 1) + acc;
   endfunction

endpackage

[hdl/cec_header_capture.sv]
module cec_header_capture
   import cec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output logic [POS_WIDTH-1:0] pos,
   output hdr_type              hdr_next,
   output logic                 in_window
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   hdr_type              hdr_ff, hdr_in;
   logic [POS_WIDTH-1:0] pay_idx;

   assign pos = pos_ff;
   assign pay_idx = pos_ff - ENV_BYTES;

   // Bytes past the header are payload while their offset is below the length.
   assign in_window = (pos_ff >= ENV_BYTES) &&
                      ({31'b0, pay_idx} < hdr_ff.length);

   always_comb begin
      hdr_next = hdr_ff;
      if (pos_ff < 33'd4) begin
         if (data_byte != magic_byte(pos_ff[1:0])) begin
            hdr_next.magic_bad[pos_ff[1:0]] = 1'b1;
         end
      end else if (pos_ff < 33'd6) begin
         hdr_next.version[8*pos_ff[0] +: 8] = data_byte;
      end else if (pos_ff < 33'd8) begin
         hdr_next.reserved[8*pos_ff[0] +: 8] = data_byte;
      end else if (pos_ff < 33'd16) begin
         hdr_next.length[8*pos_ff[2:0] +: 8] = data_byte;
      end else if (pos_ff < ENV_BYTES) begin
         hdr_next.sum[8*pos_ff[2:0] +: 8] = data_byte;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      if (step) begin
         if (last_byte) begin
            pos_in = '0;
            hdr_in = '0;
         end else begin
            hdr_in = hdr_next;
            if (pos_ff < POS_SAT) begin
               pos_in = pos_ff + 33'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hdr_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule

[hdl/cec_fnv_hash.sv]
module cec_fnv_hash
   import cec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic        in_window,
   output logic [63:0] acc_next
);

   logic [63:0] acc_ff, acc_in;

   assign acc_next = in_window ? fnv_mul(acc_ff ^ {56'b0, data_byte}) : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (step) begin
         acc_in = last_byte ? FNV_BASIS : acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= FNV_BASIS;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[hdl/cec_status_eval.sv]
module cec_status_eval
   import cec_pkg::*;
(
   input  logic [POS_WIDTH-1:0] pos,
   input  hdr_type              hdr,
   input  logic [63:0]          fnv,
   input  logic [15:0]          protocol_version,
   input  logic [31:0]          max_encoded_bytes,
   output status_type           status
);

   logic [POS_WIDTH-1:0] total;
   logic [POS_WIDTH-1:0] room;
   logic [31:0]          limit_room;

   assign total = pos + 33'd1;
   assign room = total - ENV_BYTES;
   assign limit_room = max_encoded_bytes - 32'd24;

   always_comb begin
      if (max_encoded_bytes < 32'd24) begin
         status = ST_INVALID;
      end else if (total > {1'b0, max_encoded_bytes}) begin
         status = ST_LIMIT;
      end else if (hdr.magic_bad[0]) begin
         status = ST_MAGIC;
      end else if (total <= 33'd1) begin
         status = ST_TRUNC;
      end else if (hdr.magic_bad[1]) begin
         status = ST_MAGIC;
      end else if (total <= 33'd2) begin
         status = ST_TRUNC;
      end else if (hdr.magic_bad[2]) begin
         status = ST_MAGIC;
      end else if (total <= 33'd3) begin
         status = ST_TRUNC;
      end else if (hdr.magic_bad[3]) begin
         status = ST_MAGIC;
      end else if (total < 33'd16) begin
         status = ST_TRUNC;
      end else if (hdr.length > {32'b0, limit_room}) begin
         status = ST_LIMIT;
      end else if (total < ENV_BYTES) begin
         status = ST_TRUNC;
      end else if (hdr.version != protocol_version) begin
         status = ST_VERSION;
      end else if (hdr.reserved != 16'd0) begin
         status = ST_INVALID;
      end else if (hdr.length > {31'b0, room}) begin
         status = ST_TRUNC;
      end else if (hdr.length < {31'b0, room}) begin
         status = ST_TRAILING;
      end else if (fnv != hdr.sum) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_OK;
      end
   end

endmodule

[hdl/checksummed_envelope_checker.sv]
// Envelope checker for byte streams framed with a 24-byte SWRW header and an
// FNV-1a 64 payload checksum.
// The req channel takes one byte per item with a last-byte flag. Every
// accepted item produces exactly one rsp item: the byte itself when it lies in
// the payload window, and on the last byte of a buffer the frame status.
// The csr channel writes protocol_version (index 0) or max_encoded_bytes
// (index 1); it is always ready and should be used only while no item is in
// flight.
// An item accepted on req is held in the input register, moved into the
// result register when rsp can advance, and is shown on rsp from then on.
// One item per cycle is sustained while rsp is not stalled; the per-byte limit
// is the FNV-1a update: a combinational 64-bit shift-and-add prime multiply.
// A stalled rsp holds its item while the input register keeps taking one more
// item; req_ready drops only when both registers are full and rsp is stalled.
// Reset empties both registers, resets the frame state and restores the csr
// registers to version 1 and a 65536-byte limit.
module checksummed_envelope_checker
   import cec_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [15:0]          version_ff;
   logic [31:0]          max_bytes_ff;
   logic                 in_v_ff, in_v_in;
   req_type              in_item_ff;
   logic                 out_v_ff, out_v_in;
   rsp_type              out_item_ff, out_item_in;
   logic                 advance;
   logic                 step;
   logic [POS_WIDTH-1:0] pos;
   hdr_type              hdr_next;
   logic                 in_window;
   logic [63:0]          fnv_next;
   status_type           status;

   assign advance = !out_v_ff || rsp_ready;
   assign step = in_v_ff && advance;
   assign req_ready = !in_v_ff || advance;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_item_ff;
   assign csr_ready = 1'b1;

   cec_header_capture u_header (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_item_ff.data_byte),
      .last_byte (in_item_ff.last_byte),
      .pos       (pos),
      .hdr_next  (hdr_next),
      .in_window (in_window)
   );

   cec_fnv_hash u_fnv (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_item_ff.data_byte),
      .last_byte (in_item_ff.last_byte),
      .in_window (in_window),
      .acc_next  (fnv_next)
   );

   cec_status_eval u_status (
      .pos               (pos),
      .hdr               (hdr_next),
      .fnv               (fnv_next),
      .protocol_version  (version_ff),
      .max_encoded_bytes (max_bytes_ff),
      .status            (status)
   );

   always_comb begin
      out_item_in.payload_valid = in_window;
      out_item_in.payload_out = in_window ? in_item_ff.data_byte : 8'd0;
      out_item_in.frame_done = in_item_ff.last_byte;
      out_item_in.status = in_item_ff.last_byte ? status : ST_OK;
   end

   always_comb begin
      in_v_in = in_v_ff;
      if (req_ready) begin
         in_v_in = req_valid;
      end
      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         version_ff <= 16'd1;
         max_bytes_ff <= 32'd65536;
      end else begin
         in_v_ff <= in_v_in;
         out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROTOCOL_VERSION:  version_ff <= csr_wdata[15:0];
               CSR_MAX_ENCODED_BYTES: max_bytes_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (step) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule
